FILE: rtl/fmss_pkg.sv
// ----------------------------------------------------------------------------
// fmss_pkg
// shared types and codes for the first-match string search
// ----------------------------------------------------------------------------
`default_nettype none

package fmss_pkg;

    localparam int BYTE_W = 8;

    typedef enum logic {
        OP_PATTERN = 1'b0,
        OP_TEXT    = 1'b1
    } op_t;

    // control broadcast to every cell of the compare chain
    typedef struct packed {
        logic              shift;
        logic              clear;
        logic [BYTE_W-1:0] data_byte;
    } cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/fmss_cell.sv
// ----------------------------------------------------------------------------
// fmss_cell
// one pattern position: stored byte and its partial-match bit
// ----------------------------------------------------------------------------
`default_nettype none

module fmss_cell (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire fmss_pkg::cell_ctl_t            ctl,
    input  wire logic                           wr_en,
    input  wire logic                           pv_in,
    output logic                                hit,
    output logic                                pv_out
);

    logic [fmss_pkg::BYTE_W-1:0] store_reg;
    logic                        pv_reg;
    logic                        pv_next;

    assign hit    = pv_in && (store_reg == ctl.data_byte);
    assign pv_out = pv_reg;

    always_comb begin
        pv_next = pv_reg;
        if (ctl.clear) begin
            pv_next = 1'b0;
        end else if (ctl.shift) begin
            pv_next = hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
        end else begin
            pv_reg <= pv_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_reg <= ctl.data_byte;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/fmss_out_buf.sv
// ----------------------------------------------------------------------------
// fmss_out_buf
// two-entry result buffer: output register plus skid register
// ----------------------------------------------------------------------------
`default_nettype none

module fmss_out_buf #(
    parameter int W = 24
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire logic [W-1:0] push_data,
    output logic              can_push,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [W-1:0]      m_tdata
);

    logic         out_valid_reg, out_valid_next;
    logic [W-1:0] out_data_reg, out_data_next;
    logic         skid_valid_reg, skid_valid_next;
    logic [W-1:0] skid_data_reg, skid_data_next;

    assign can_push = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

FILE: rtl/first_match_string_search.sv
// ----------------------------------------------------------------------------
// first_match_string_search
// earliest occurrence of a byte pattern in a streamed byte text
// ----------------------------------------------------------------------------
// s_ channel: tuser selects the transaction kind (0 pattern byte, 1 text
// byte), tdata carries the byte, tlast ends the pattern or the text. the
// pattern is loaded first; its last byte fixes the length, bytes past
// MAX_PATTERN are dropped. text then streams at one byte per cycle through
// a chain of MAX_PATTERN compare cells, each holding one pattern byte and
// passing its partial-match bit to the next cell on every text byte.
// m_ channel: one transaction per text, issued for the last text byte, with
// found and the zero-based start of the earliest match (0 if none). it
// is held in the buffer's output or, if the receiver stalls, skid register.
// throughput is one byte per cycle. a two-entry result buffer keeps s_tready
// high while a result waits; s_tready drops only when both entries are full
// because the receiver stalls. reset empties the buffer, clears the match
// state and sets the pattern length to zero (empty pattern matches at 0).
// ----------------------------------------------------------------------------
`default_nettype none

module first_match_string_search #(
    parameter int MAX_PATTERN   = 64,
    parameter int POSITION_BITS = 20
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    input  wire logic [7:0]                             s_tdata,  // data_byte
    input  wire logic                                   s_tuser,  // operation
    input  wire logic                                   s_tlast,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // found, match_position, zero fill
    output logic [((POSITION_BITS+8)/8)*8-1:0]          m_tdata
);

    localparam int OUT_W = ((POSITION_BITS + 8) / 8) * 8;
    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int SUM_W = ((POSITION_BITS > LEN_W) ? POSITION_BITS : LEN_W) + 1;
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    logic                      accept;
    logic                      is_pattern;
    logic                      is_text;
    fmss_pkg::cell_ctl_t       ctl;
    logic [MAX_PATTERN-1:0]    wr_en;
    logic [MAX_PATTERN-1:0]    hit;
    logic [MAX_PATTERN-1:0]    pv;
    logic [MAX_PATTERN-1:0]    chain_in;

    logic [LEN_W-1:0]          len_reg, len_next;
    logic [LEN_W-1:0]          load_idx_reg, load_idx_next;
    logic [POSITION_BITS-1:0]  pos_reg, pos_next;
    logic                      seen_reg, seen_next;
    logic [POSITION_BITS-1:0]  start_reg, start_next;

    logic                      in_range;
    logic [LEN_W-1:0]          len_m1;
    logic                      full_hit;
    logic [SUM_W-1:0]          start_sum;
    logic                      seen_now;
    logic [POSITION_BITS-1:0]  start_now;
    logic                      push;
    logic [OUT_W-1:0]          push_data;
    logic                      can_push;

    assign accept     = s_tvalid && s_tready;
    assign s_tready   = can_push;
    assign is_pattern = accept && (fmss_pkg::op_t'(s_tuser) == fmss_pkg::OP_PATTERN);
    assign is_text    = accept && (fmss_pkg::op_t'(s_tuser) == fmss_pkg::OP_TEXT);

    assign ctl.shift     = is_text;
    assign ctl.clear     = is_pattern || (is_text && s_tlast);
    assign ctl.data_byte = s_tdata;

    genvar j;
    generate
        for (j = 0; j < MAX_PATTERN; j++) begin : g_cell
            assign wr_en[j] = is_pattern && (load_idx_reg == LEN_W'(j));
            if (j == 0) begin : g_head
                assign chain_in[j] = 1'b1;
            end else begin : g_link
                assign chain_in[j] = pv[j-1];
            end
            fmss_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctl     (ctl),
                .wr_en   (wr_en[j]),
                .pv_in   (chain_in[j]),
                .hit     (hit[j]),
                .pv_out  (pv[j])
            );
        end
    endgenerate

    assign in_range  = (pos_reg != POS_MAX);
    assign len_m1    = LEN_W'(len_reg - LEN_W'(1));
    assign full_hit  = hit[len_m1[IDX_W-1:0]];
    assign start_sum = SUM_W'(pos_reg) + SUM_W'(1) - SUM_W'(len_reg);

    always_comb begin
        len_next      = len_reg;
        load_idx_next = load_idx_reg;
        pos_next      = pos_reg;
        seen_now      = seen_reg;
        start_now     = start_reg;
        seen_next     = seen_reg;
        start_next    = start_reg;
        push          = 1'b0;
        push_data     = '0;
        if (is_pattern) begin
            if (load_idx_reg < LEN_W'(MAX_PATTERN)) begin
                load_idx_next = LEN_W'(load_idx_reg + LEN_W'(1));
            end
            if (s_tlast) begin
                len_next      = load_idx_next;
                load_idx_next = '0;
            end
            pos_next   = '0;
            seen_next  = 1'b0;
            start_next = '0;
        end else if (is_text) begin
            if (len_reg == '0) begin
                if (!seen_reg) begin
                    seen_now  = 1'b1;
                    start_now = '0;
                end
            end else if (full_hit && !seen_reg && in_range) begin
                seen_now  = 1'b1;
                start_now = start_sum[POSITION_BITS-1:0];
            end
            if (in_range) begin
                pos_next = POSITION_BITS'(pos_reg + POSITION_BITS'(1));
            end
            seen_next  = seen_now;
            start_next = start_now;
            if (s_tlast) begin
                push         = 1'b1;
                push_data[0] = seen_now;
                push_data[POSITION_BITS:1] = seen_now ? start_now : '0;
                pos_next   = '0;
                seen_next  = 1'b0;
                start_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg      <= '0;
            load_idx_reg <= '0;
            pos_reg      <= '0;
            seen_reg     <= 1'b0;
            start_reg    <= '0;
        end else begin
            len_reg      <= len_next;
            load_idx_reg <= load_idx_next;
            pos_reg      <= pos_next;
            seen_reg     <= seen_next;
            start_reg    <= start_next;
        end
    end

    fmss_out_buf #(
        .W (OUT_W)
    ) u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .can_push  (can_push),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // pattern transaction wipes the partial-match chain
    a_pattern_clears_chain : assert property (@(posedge aclk) disable iff (!aresetn)
        is_pattern |=> (pv == '0))
        else $error("partial-match chain not cleared by pattern byte");

    a_start_zero_when_unseen : assert property (@(posedge aclk) disable iff (!aresetn)
        !seen_reg |-> (start_reg == '0))
        else $error("match start held without a match");

    a_load_idx_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        load_idx_reg <= LEN_W'(MAX_PATTERN))
        else $error("load index beyond pattern capacity");

    a_result_after_last_text : assert property (@(posedge aclk) disable iff (!aresetn)
        (is_text && s_tlast) |=> (pos_reg == '0) && !seen_reg && m_tvalid)
        else $error("text end not followed by result and cleared state");

endmodule

`default_nettype wire
